[hdl/safe_interval_table_macros.svh]
// Assertion macros shared by the checker.
`ifndef SAFE_INTERVAL_TABLE_MACROS_SVH
`define SAFE_INTERVAL_TABLE_MACROS_SVH
// Implication checked at every edge outside reset.
`define SIT_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("safe_interval_table: check failed");
// Next-cycle implication checked outside reset.
`define SIT_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("safe_interval_table: check failed");
`endif

[hdl/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg
// Types and codes shared by the safe interval table modules.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int unsigned OutTimeBits = 32;

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_HEAD,
    BK_RD,
    BK_EVAL,
    BK_SHIFT,
    BK_OUT,
    BK_DONE
  } bk_state_e;

endpackage

[hdl/sit_front.sv]
// ----------------------------------------------------------------------------
// sit_front
// Accepts commands, checks the cell address and holds one decoded request at a time.
// ----------------------------------------------------------------------------
module sit_front #(
  parameter int unsigned CellBits  = 12,
  parameter int unsigned TimeBits  = 32,
  parameter int unsigned XBits     = 6,
  parameter int unsigned YBits     = 6,
  parameter int unsigned GridWidth = 64,
  parameter int unsigned GridHeight = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic [5:0]          cell_x_i,
  input  logic [5:0]          cell_y_i,
  input  logic                occupied_flag_i,
  input  logic [31:0]         span_start_i,
  input  logic [31:0]         span_end_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output sit_pkg::req_e       q_req_o,
  output logic [CellBits-1:0] q_cell_o,
  output logic                q_occ_o,
  output logic [TimeBits-1:0] q_s_o,
  output logic [TimeBits-1:0] q_e_o
);

  logic                full_q, full_d;
  sit_pkg::req_e       req_q;
  logic [CellBits-1:0] cell_q;
  logic                occ_q;
  logic [TimeBits-1:0] s_q, e_q;
  logic                in_grid;
  logic [CellBits-1:0] cell_idx;
  logic [TimeBits-1:0] s_in, e_in;

  assign in_grid = ({26'd0, cell_x_i} < 32'(GridWidth)) &&
                   ({26'd0, cell_y_i} < 32'(GridHeight));
  assign cell_idx = CellBits'(32'(cell_y_i) * 32'(GridWidth) + 32'(cell_x_i));

  always_comb begin
    s_in = TimeBits'({{(TimeBits > 32 ? TimeBits - 32 : 1){1'b0}}, span_start_i});
    if (span_end_i == '1) begin
      e_in = '1;
    end else begin
      e_in = TimeBits'({{(TimeBits > 32 ? TimeBits - 32 : 1){1'b0}}, span_end_i});
    end
  end

  assign busy  = full_q;
  assign full_d = (start && !full_q) ? 1'b1 : (q_pop_i ? 1'b0 : full_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !full_q) begin
      req_q  <= in_grid ? sit_pkg::req_e'(req_type_i) : sit_pkg::REQ_NONE;
      cell_q <= cell_idx;
      occ_q  <= occupied_flag_i;
      s_q    <= s_in;
      e_q    <= e_in;
    end
  end

  assign q_valid_o = full_q;
  assign q_req_o   = req_q;
  assign q_cell_o  = cell_q;
  assign q_occ_o   = occ_q;
  assign q_s_o     = s_q;
  assign q_e_o     = e_q;

endmodule

[hdl/sit_back.sv]
// ----------------------------------------------------------------------------
// sit_back
// Walks and updates a cell's interval list held in memory, emits results.
// ----------------------------------------------------------------------------
module sit_back #(
  parameter int unsigned NumCells     = 4096,
  parameter int unsigned CellBits     = 12,
  parameter int unsigned MaxIntervals = 8,
  parameter int unsigned TimeBits     = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          tol_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  sit_pkg::req_e       q_req_i,
  input  logic [CellBits-1:0] q_cell_i,
  input  logic                q_occ_i,
  input  logic [TimeBits-1:0] q_s_i,
  input  logic [TimeBits-1:0] q_e_i,
  output logic                res_o,
  output logic [1:0]          status_o,
  output logic                entry_valid_o,
  output logic [31:0]         interval_start_o,
  output logic [31:0]         interval_end_o,
  output logic                interval_safe_o,
  output logic                last_o
);

  localparam int unsigned SlotBits = $clog2(MaxIntervals);
  localparam int unsigned CntBits  = $clog2(MaxIntervals + 1);
  localparam int unsigned AddrBits = CellBits + SlotBits;
  localparam int unsigned EntBits  = 2 * TimeBits + 1;
  localparam logic [TimeBits-1:0] TimeInf = '1;

  // Per-cell header: blocked flag and interval count, set up by a pass after reset.
  logic [CntBits:0]        hdr_mem [NumCells];
  logic [EntBits-1:0]      ent_mem [NumCells * MaxIntervals];
  logic [CntBits:0]        hdr_rd_q;
  logic [EntBits-1:0]      ent_rd_q;

  sit_pkg::bk_state_e      st_q, st_d;
  logic [CellBits-1:0]     init_q, init_d;
  logic [SlotBits-1:0]     i_q, i_d;
  logic [SlotBits-1:0]     j_q, j_d;
  logic [CntBits-1:0]      n_q, n_d;
  logic                    blk_q, blk_d;
  logic [1:0]              status_q, status_d;
  logic                    shift_up_q, shift_up_d;
  logic                    split_q, split_d;
  logic [TimeBits-1:0]     ts_q, te_q, tis_q;

  logic                    hdr_we;
  logic [CellBits-1:0]     hdr_wa;
  logic [CntBits:0]        hdr_wd;
  logic                    ent_we;
  logic [AddrBits-1:0]     ent_wa, ent_ra;
  logic [EntBits-1:0]      ent_wd;
  logic                    ent_re;
  logic [SlotBits-1:0]     ent_rslot;

  logic                    cur_safe;
  logic [TimeBits-1:0]     cur_s, cur_e;
  logic                    res_d;
  logic [1:0]              ro_status;
  logic                    ro_valid, ro_safe, ro_last;
  logic [31:0]             ro_s, ro_e;

  function automatic logic [TimeBits-1:0] tadd(input logic [TimeBits-1:0] t,
                                                input logic [7:0] tol);
    logic [TimeBits:0] sum;
    sum = {1'b0, t} + {{(TimeBits - 7){1'b0}}, tol};
    return sum[TimeBits] ? TimeInf : sum[TimeBits-1:0];
  endfunction

  function automatic logic [AddrBits-1:0] eaddr(input logic [CellBits-1:0] c,
                                                input logic [SlotBits-1:0] s);
    return {c, s};
  endfunction

  assign cur_safe = ent_rd_q[0];
  assign cur_s    = ent_rd_q[EntBits-1 -: TimeBits];
  assign cur_e    = ent_rd_q[TimeBits:1];

  logic [TimeBits-1:0] stol, etol, istol;
  assign stol  = tadd(ts_q, tol_i);
  assign etol  = tadd(te_q, tol_i);
  assign istol = tadd(cur_s, tol_i);

  always_comb begin
    st_d       = st_q;
    init_d     = init_q;
    i_d        = i_q;
    j_d        = j_q;
    n_d        = n_q;
    blk_d      = blk_q;
    status_d   = status_q;
    shift_up_d = shift_up_q;
    split_d    = split_q;
    q_pop_o    = 1'b0;
    hdr_we     = 1'b0;
    hdr_wa     = q_cell_i;
    hdr_wd     = {blk_q, n_q};
    ent_we     = 1'b0;
    ent_wa     = eaddr(q_cell_i, i_q);
    ent_wd     = ent_rd_q;
    ent_re     = 1'b0;
    ent_rslot  = i_q;
    res_d      = 1'b0;
    ro_status  = sit_pkg::ST_OK;
    ro_valid   = 1'b0;
    ro_s       = '0;
    ro_e       = '0;
    ro_safe    = 1'b0;
    ro_last    = 1'b1;
    case (st_q)
      sit_pkg::BK_INIT: begin
        hdr_we = 1'b1;
        hdr_wa = init_q;
        hdr_wd = {1'b0, CntBits'(1)};
        ent_we = 1'b1;
        ent_wa = eaddr(init_q, '0);
        ent_wd = {{TimeBits{1'b0}}, TimeInf, 1'b1};
        init_d = init_q + CellBits'(1);
        if (init_q == CellBits'(NumCells - 1)) begin
          st_d = sit_pkg::BK_IDLE;
        end
      end
      sit_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          case (q_req_i)
            sit_pkg::REQ_SET: begin
              hdr_we = 1'b1;
              hdr_wd = {q_occ_i, CntBits'(1)};
              ent_we = 1'b1;
              ent_wa = eaddr(q_cell_i, '0);
              ent_wd = {q_occ_i ? TimeInf : {TimeBits{1'b0}}, TimeInf, ~q_occ_i};
              res_d  = 1'b1;
              q_pop_o = 1'b1;
            end
            sit_pkg::REQ_ADD, sit_pkg::REQ_READ: begin
              st_d = sit_pkg::BK_HEAD;
            end
            default: begin
              res_d   = 1'b1;
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      sit_pkg::BK_HEAD: begin
        blk_d = hdr_rd_q[CntBits];
        n_d   = hdr_rd_q[CntBits-1:0];
        i_d = '0;
        status_d = sit_pkg::ST_OK;
        if (q_req_i == sit_pkg::REQ_READ) begin
          ent_re = 1'b1;
          ent_rslot = '0;
          st_d = sit_pkg::BK_OUT;
        end else if (tadd(ts_q, tol_i) > te_q) begin
          status_d = sit_pkg::ST_INVALID;
          st_d = sit_pkg::BK_DONE;
        end else if (hdr_rd_q[CntBits]) begin
          st_d = sit_pkg::BK_DONE;
        end else if (hdr_rd_q[CntBits-1:0] == '0) begin
          st_d = sit_pkg::BK_DONE;
        end else begin
          ent_re = 1'b1;
          ent_rslot = '0;
          st_d = sit_pkg::BK_EVAL;
        end
      end
      sit_pkg::BK_OUT: begin
        res_d     = 1'b1;
        q_pop_o   = 1'b0;
        if (n_q == '0) begin
          ro_last = 1'b1;
          q_pop_o = 1'b1;
          st_d    = sit_pkg::BK_IDLE;
        end else begin
          ro_valid = 1'b1;
          ro_s     = ts_q[31:0];
          ro_e     = te_q[31:0];
          ro_safe  = cur_safe;
          ro_s     = 32'(cur_s);
          ro_e     = 32'(cur_e);
          ro_last  = (CntBits'(i_q) + CntBits'(1) == n_q);
          if (ro_last) begin
            q_pop_o = 1'b1;
            st_d    = sit_pkg::BK_IDLE;
          end else begin
            i_d       = i_q + SlotBits'(1);
            ent_re    = 1'b1;
            ent_rslot = i_q + SlotBits'(1);
            st_d      = sit_pkg::BK_RD;
          end
        end
      end
      sit_pkg::BK_RD: begin
        st_d = (q_req_i == sit_pkg::REQ_READ) ? sit_pkg::BK_OUT : sit_pkg::BK_EVAL;
      end
      sit_pkg::BK_EVAL: begin
        if (!cur_safe) begin
          // Erase: shift later entries down by one.
          shift_up_d = 1'b0;
          split_d    = 1'b0;
          j_d        = i_q;
          n_d        = n_q - CntBits'(1);
          if (CntBits'(i_q) + CntBits'(1) >= n_q) begin
            st_d = sit_pkg::BK_DONE;
          end else begin
            ent_re = 1'b1;
            ent_rslot = i_q + SlotBits'(1);
            st_d = sit_pkg::BK_SHIFT;
          end
        end else if (stol >= cur_e) begin
          if (CntBits'(i_q) + CntBits'(1) >= n_q) begin
            st_d = sit_pkg::BK_DONE;
          end else begin
            i_d = i_q + SlotBits'(1);
            ent_re = 1'b1;
            ent_rslot = i_q + SlotBits'(1);
            st_d = sit_pkg::BK_RD;
          end
        end else if (istol >= te_q) begin
          st_d = sit_pkg::BK_DONE;
        end else if (ts_q > istol && etol >= cur_e) begin
          ent_we = 1'b1;
          ent_wd = {cur_s, ts_q, 1'b1};
          if (CntBits'(i_q) + CntBits'(1) >= n_q) begin
            st_d = sit_pkg::BK_DONE;
          end else begin
            i_d = i_q + SlotBits'(1);
            ent_re = 1'b1;
            ent_rslot = i_q + SlotBits'(1);
            st_d = sit_pkg::BK_RD;
          end
        end else if (istol >= ts_q && cur_e > etol) begin
          ent_we = 1'b1;
          ent_wd = {te_q, cur_e, 1'b1};
          st_d = sit_pkg::BK_DONE;
        end else if (ts_q > istol && cur_e > etol) begin
          if (32'(n_q) >= 32'(MaxIntervals)) begin
            status_d = sit_pkg::ST_FULL;
            st_d = sit_pkg::BK_DONE;
          end else begin
            // Split: move entries i..n-1 up by one from the top, then patch.
            shift_up_d = 1'b1;
            split_d    = 1'b1;
            j_d        = SlotBits'(n_q);
            n_d        = n_q + CntBits'(1);
            if (n_q == CntBits'(i_q) + CntBits'(1)) begin
              ent_wa = eaddr(q_cell_i, i_q + SlotBits'(1));
              ent_we = 1'b1;
              ent_wd = {te_q, cur_e, 1'b1};
              st_d   = sit_pkg::BK_SHIFT;
              j_d    = i_q;
            end else begin
              ent_re = 1'b1;
              ent_rslot = SlotBits'(n_q - CntBits'(1));
              st_d = sit_pkg::BK_SHIFT;
            end
          end
        end else begin
          shift_up_d = 1'b0;
          split_d    = 1'b0;
          j_d        = i_q;
          n_d        = n_q - CntBits'(1);
          if (CntBits'(i_q) + CntBits'(1) >= n_q) begin
            st_d = sit_pkg::BK_DONE;
          end else begin
            ent_re = 1'b1;
            ent_rslot = i_q + SlotBits'(1);
            st_d = sit_pkg::BK_SHIFT;
          end
        end
      end
      sit_pkg::BK_SHIFT: begin
        if (!shift_up_q) begin
          // ent_rd_q holds entry j+1; write it to j.
          ent_we = 1'b1;
          ent_wa = eaddr(q_cell_i, j_q);
          ent_wd = ent_rd_q;
          j_d    = j_q + SlotBits'(1);
          if (CntBits'(j_q) + CntBits'(2) > n_q) begin
            // n_q already decremented: stop once j+1 reaches old end.
            ent_re    = 1'b1;
            ent_rslot = i_q;
            st_d      = sit_pkg::BK_RD;
          end else begin
            ent_re    = 1'b1;
            ent_rslot = j_q + SlotBits'(2);
            st_d      = sit_pkg::BK_SHIFT;
          end
        end else if (j_q == i_q) begin
          // Patch the split pair.
          ent_we = 1'b1;
          ent_wa = eaddr(q_cell_i, i_q);
          ent_wd = {tis_q, ts_q, 1'b1};
          st_d   = sit_pkg::BK_DONE;
        end else begin
          ent_we = 1'b1;
          ent_wa = eaddr(q_cell_i, j_q);
          ent_wd = (j_q == i_q + SlotBits'(1)) ? {te_q, ent_rd_q[TimeBits:0]} : ent_rd_q;
          j_d    = j_q - SlotBits'(1);
          if (j_q - SlotBits'(1) != i_q) begin
            ent_re = 1'b1;
            ent_rslot = j_q - SlotBits'(2);
          end else begin
            ent_re = 1'b1;
            ent_rslot = i_q;
          end
        end
      end
      sit_pkg::BK_DONE: begin
        hdr_we    = 1'b1;
        hdr_wd    = {blk_q, n_q};
        res_d     = 1'b1;
        ro_status = status_q;
        q_pop_o   = 1'b1;
        st_d      = sit_pkg::BK_IDLE;
      end
      default: begin
        st_d = sit_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= sit_pkg::BK_INIT;
      init_q     <= '0;
      res_o      <= 1'b0;
    end else begin
      st_q   <= st_d;
      init_q <= init_d;
      res_o  <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    n_q        <= n_d;
    blk_q      <= blk_d;
    status_q   <= status_d;
    shift_up_q <= shift_up_d;
    split_q    <= split_d;
    ts_q       <= q_s_i;
    te_q       <= q_e_i;
    if (st_q == sit_pkg::BK_EVAL) begin
      tis_q <= cur_s;
    end
    status_o         <= ro_status;
    entry_valid_o    <= ro_valid;
    interval_start_o <= ro_s;
    interval_end_o   <= ro_e;
    interval_safe_o  <= ro_safe;
    last_o           <= ro_last;
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[hdr_wa] <= hdr_wd;
    end
    hdr_rd_q <= hdr_mem[q_cell_i];
  end

  assign ent_ra = eaddr(q_cell_i, ent_rslot);

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_re) begin
      if (ent_we && ent_wa == ent_ra) begin
        ent_rd_q <= ent_wd;
      end else begin
        ent_rd_q <= ent_mem[ent_ra];
      end
    end
  end

endmodule

[hdl/safe_interval_table.sv]
// ----------------------------------------------------------------------------
// safe_interval_table
// Per-cell safe interval reservation table with set, collision and read.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// command   in         start / busy       req_type, cell, flag, span
// config    in         cfg_valid/ready    time_tolerance
// result    out        res_strobe         status, entry, last
// After reset a clearing pass, one cell per cycle, sets every cell free; a command
// accepted during it waits for the pass. A set cell or an unused request gives a
// single result beat. A read gives one beat per interval, or one status beat for
// an empty list. A collision walks the list entry by entry and ends in one status
// beat; a rejected span, a blocked cell or an empty list stops it before the walk,
// and an erase or a split also moves the later entries by one slot.
// Reset is asynchronous; the receiver cannot stall results.
module safe_interval_table #(
  parameter int unsigned GRID_WIDTH    = 64,
  parameter int unsigned GRID_HEIGHT   = 64,
  parameter int unsigned MAX_INTERVALS = 8,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        occupied_flag_i,
  input  logic [31:0] span_start_i,
  input  logic [31:0] span_end_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        res_strobe_o,
  output logic [1:0]  status_o,
  output logic        entry_valid_o,
  output logic [31:0] interval_start_o,
  output logic [31:0] interval_end_o,
  output logic        interval_safe_o,
  output logic        last_o
);

  localparam int unsigned NumCells = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned CellBits = $clog2(NumCells);

  logic [7:0]          tol_q;
  logic                q_valid, q_pop, q_occ;
  sit_pkg::req_e       q_req;
  logic [CellBits-1:0] q_cell;
  logic [TIME_BITS-1:0] q_s, q_e;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  sit_front #(
    .CellBits(CellBits), .TimeBits(TIME_BITS), .XBits(6), .YBits(6),
    .GridWidth(GRID_WIDTH), .GridHeight(GRID_HEIGHT)
  ) u_front (
    .clk_i, .rst_ni, .start, .busy,
    .req_type_i, .cell_x_i, .cell_y_i, .occupied_flag_i, .span_start_i, .span_end_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req), .q_cell_o(q_cell),
    .q_occ_o(q_occ), .q_s_o(q_s), .q_e_o(q_e)
  );

  sit_back #(
    .NumCells(NumCells), .CellBits(CellBits),
    .MaxIntervals(MAX_INTERVALS), .TimeBits(TIME_BITS)
  ) u_back (
    .clk_i, .rst_ni, .tol_i(tol_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req), .q_cell_i(q_cell),
    .q_occ_i(q_occ), .q_s_i(q_s), .q_e_i(q_e),
    .res_o(res_strobe_o), .status_o, .entry_valid_o, .interval_start_o,
    .interval_end_o, .interval_safe_o, .last_o
  );

endmodule

[hdl/sit_checker.sv]
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks on the safe interval table, bound to the top level.
// ----------------------------------------------------------------------------
`include "safe_interval_table_macros.svh"

module sit_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       res_strobe_o,
  input logic [1:0] status_o,
  input logic       entry_valid_o,
  input logic       last_o
);

  `SIT_ASSERT_NXT(a_busy_after_start, clk_i, rst_ni, start && !busy, busy)
  `SIT_ASSERT_IMP(a_status_code, clk_i, rst_ni, res_strobe_o, status_o <= sit_pkg::ST_FULL)
  `SIT_ASSERT_IMP(a_entry_ok, clk_i, rst_ni, res_strobe_o && entry_valid_o, status_o == sit_pkg::ST_OK)
  `SIT_ASSERT_NXT(a_idle_after_last, clk_i, rst_ni, res_strobe_o && last_o, !res_strobe_o)

endmodule

bind safe_interval_table sit_checker u_sit_checker (
  .clk_i, .rst_ni, .start, .busy, .res_strobe_o, .status_o, .entry_valid_o, .last_o
);

[tb/sv/safe_interval_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safe_interval_table_tb
// Self-checking bench for the safe interval reservation table. Set, collision,
// read and unused requests are driven through the start/busy port. A scoreboard
// keeps its own copy of every cell's interval list, predicts each result beat
// and compares the beats seen on the strobed result port, field by field.
// Several tolerance settings and idle patterns are covered.
// ----------------------------------------------------------------------------
module safe_interval_table_tb;

  localparam logic [31:0] TimeInf = 32'hFFFF_FFFF;
  localparam int unsigned NumCells = 4096;
  localparam int unsigned MaxSlots = 8;
  localparam int unsigned StallLimit = 20000;

  typedef struct {
    sit_pkg::status_e status;
    logic        entry_valid;
    logic [31:0] t_start;
    logic [31:0] t_end;
    logic        safe;
    logic        last;
  } interval_beat_t;

  class interval_scoreboard;
    logic [7:0]  tolerance;
    bit          blocked[NumCells];
    int unsigned count[NumCells];
    logic [31:0] starts[NumCells][MaxSlots];
    logic [31:0] ends[NumCells][MaxSlots];
    bit          safe_bit[NumCells][MaxSlots];
    interval_beat_t pending_beats[$];
    int unsigned failures;

    function new();
      tolerance = '0;
      failures = 0;
      for (int c = 0; c < NumCells; c++) begin
        init_cell(c, 1'b0);
      end
    endfunction

    function void init_cell(int c, bit occ);
      blocked[c] = occ;
      count[c] = 1;
      for (int k = 0; k < MaxSlots; k++) begin
        starts[c][k] = '0;
        ends[c][k] = '0;
        safe_bit[c][k] = 1'b0;
      end
      starts[c][0] = occ ? TimeInf : 32'd0;
      ends[c][0] = TimeInf;
      safe_bit[c][0] = !occ;
    endfunction

    function logic [31:0] widen(logic [31:0] t);
      logic [32:0] sum;
      sum = {1'b0, t} + {25'd0, tolerance};
      if (t == TimeInf || sum > {1'b0, TimeInf}) return TimeInf;
      return sum[31:0];
    endfunction

    function void erase_slot(int c, int i);
      for (int j = i; j + 1 < count[c]; j++) begin
        starts[c][j] = starts[c][j+1];
        ends[c][j] = ends[c][j+1];
        safe_bit[c][j] = safe_bit[c][j+1];
      end
      count[c] = count[c] - 1;
    endfunction

    function sit_pkg::status_e carve_span(int c, logic [31:0] s, logic [31:0] e);
      int i;
      logic [31:0] is_t, ie_t;
      i = 0;
      if (widen(s) > e) return sit_pkg::ST_INVALID;
      if (blocked[c]) return sit_pkg::ST_OK;
      while (i < count[c] && i < MaxSlots) begin
        if (!safe_bit[c][i]) begin
          erase_slot(c, i);
          if (i >= count[c]) break;
        end
        is_t = starts[c][i];
        ie_t = ends[c][i];
        if (widen(s) >= ie_t) begin
          i++;
        end else if (widen(is_t) >= e) begin
          break;
        end else if (s > widen(is_t) && widen(e) >= ie_t) begin
          ends[c][i] = s;
          i++;
        end else if (widen(is_t) >= s && ie_t > widen(e)) begin
          starts[c][i] = e;
          break;
        end else if (s > widen(is_t) && ie_t > widen(e)) begin
          if (count[c] >= MaxSlots) return sit_pkg::ST_FULL;
          for (int j = count[c]; j > i; j--) begin
            starts[c][j] = starts[c][j-1];
            ends[c][j] = ends[c][j-1];
            safe_bit[c][j] = safe_bit[c][j-1];
          end
          starts[c][i] = is_t;
          ends[c][i] = s;
          safe_bit[c][i] = 1'b1;
          starts[c][i+1] = e;
          count[c] = count[c] + 1;
          break;
        end else begin
          erase_slot(c, i);
        end
      end
      return sit_pkg::ST_OK;
    endfunction

    function void queue_beat(interval_beat_t b);
      pending_beats = {pending_beats, b};
    endfunction

    function void push_status(sit_pkg::status_e st);
      interval_beat_t b;
      b = '{status: st, entry_valid: 1'b0, t_start: '0, t_end: '0, safe: 1'b0,
            last: 1'b1};
      queue_beat(b);
    endfunction

    function void note_request(sit_pkg::req_e req, logic [5:0] x, logic [5:0] y,
                               logic occ, logic [31:0] s, logic [31:0] e);
      int c;
      interval_beat_t b;
      c = int'(y) * 64 + int'(x);
      case (req)
        sit_pkg::REQ_SET: begin
          init_cell(c, occ);
          push_status(sit_pkg::ST_OK);
        end
        sit_pkg::REQ_ADD: push_status(carve_span(c, s, e));
        sit_pkg::REQ_READ: begin
          if (count[c] == 0) push_status(sit_pkg::ST_OK);
          for (int k = 0; k < count[c]; k++) begin
            b = '{status: sit_pkg::ST_OK, entry_valid: 1'b1, t_start: starts[c][k],
                  t_end: ends[c][k], safe: safe_bit[c][k], last: k + 1 == count[c]};
            queue_beat(b);
          end
        end
        default: push_status(sit_pkg::ST_OK);
      endcase
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: mismatch in %s, expected %h, actual %h", $time, field, exp_v,
                 act_v);
        failures++;
      end
    endfunction

    function void check_result(interval_beat_t act);
      interval_beat_t exp_b;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d",
                 $time, act.status);
        failures++;
        return;
      end
      exp_b = pending_beats.pop_front();
      compare("status", exp_b.status, act.status);
      compare("entry_valid", exp_b.entry_valid, act.entry_valid);
      compare("interval_start", exp_b.t_start, act.t_start);
      compare("interval_end", exp_b.t_end, act.t_end);
      compare("interval_safe", exp_b.safe, act.safe);
      compare("last", exp_b.last, act.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic        occupied_flag;
  logic [31:0] span_start;
  logic [31:0] span_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        res_strobe;
  logic [1:0]  status;
  logic        entry_valid;
  logic [31:0] interval_start;
  logic [31:0] interval_end;
  logic        interval_safe;
  logic        last;

  interval_scoreboard table_sb;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  safe_interval_table DUT (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .req_type_i(req_type), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .occupied_flag_i(occupied_flag), .span_start_i(span_start), .span_end_i(span_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .res_strobe_o(res_strobe), .status_o(status), .entry_valid_o(entry_valid),
    .interval_start_o(interval_start), .interval_end_o(interval_end),
    .interval_safe_o(interval_safe), .last_o(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && res_strobe) begin
      table_sb.check_result('{status: sit_pkg::status_e'(status),
                              entry_valid: entry_valid,
                              t_start: interval_start, t_end: interval_end,
                              safe: interval_safe, last: last});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_request(sit_pkg::req_e req, logic [5:0] x, logic [5:0] y,
                              logic occ, logic [31:0] s, logic [31:0] e);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    req_type = req;
    cell_x = x;
    cell_y = y;
    occupied_flag = occ;
    span_start = s;
    span_end = e;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    table_sb.note_request(req, x, y, occ, s, e);
    @(negedge clk);
  endtask

  task automatic write_tolerance(logic [7:0] value);
    start = 1'b0;
    while (table_sb.pending_beats.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    table_sb.tolerance = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(9))
      0: return TimeInf;
      1: return $urandom();
      2: return 32'd0;
      default: return $urandom_range(600);
    endcase
  endfunction

  task automatic random_request();
    int unsigned sel;
    logic [5:0] x, y;
    logic [31:0] a, b;
    sel = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      x = 6'($urandom());
      y = 6'($urandom());
    end else begin
      x = 6'($urandom_range(3));
      y = 6'd0;
    end
    a = pick_time();
    b = pick_time();
    if ($urandom_range(99) < 85 && a > b) begin
      {a, b} = {b, a};
    end
    if (sel < 60) send_request(sit_pkg::REQ_ADD, x, y, 1'($urandom()), a, b);
    else if (sel < 85) send_request(sit_pkg::REQ_READ, x, y, 1'($urandom()), a, b);
    else if (sel < 95) send_request(sit_pkg::REQ_SET, x, y, $urandom_range(99) < 30, a, b);
    else send_request(sit_pkg::REQ_NONE, x, y, 1'($urandom()), a, b);
  endtask

  initial begin
    logic [7:0] tol_values[4];
    int unsigned idle_values[4];
    tol_values = '{8'd0, 8'd255, 8'd1, 8'd200};
    idle_values = '{35, 84, 0, 0};
    table_sb = new();
    quiet_cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    req_type = sit_pkg::REQ_SET;
    cell_x = '0;
    cell_y = '0;
    occupied_flag = 1'b0;
    span_start = '0;
    span_end = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request(sit_pkg::REQ_READ, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0);
    send_request(sit_pkg::REQ_READ, 6'd63, 6'd63, 1'b1, TimeInf, TimeInf);
    send_request(sit_pkg::REQ_ADD, 6'd1, 6'd0, 1'b0, 32'd100, 32'd200);
    send_request(sit_pkg::REQ_ADD, 6'd1, 6'd0, 1'b0, 32'd50, 32'd100);
    send_request(sit_pkg::REQ_ADD, 6'd1, 6'd0, 1'b0, 32'd200, 32'd300);
    send_request(sit_pkg::REQ_ADD, 6'd1, 6'd0, 1'b0, 32'd500, 32'd400);
    send_request(sit_pkg::REQ_ADD, 6'd1, 6'd0, 1'b0, 32'd10, 32'd10);
    send_request(sit_pkg::REQ_ADD, 6'd1, 6'd0, 1'b0, TimeInf, TimeInf);
    send_request(sit_pkg::REQ_READ, 6'd1, 6'd0, 1'b0, 32'd0, 32'd0);
    send_request(sit_pkg::REQ_ADD, 6'd2, 6'd0, 1'b0, 32'd0, TimeInf);
    send_request(sit_pkg::REQ_READ, 6'd2, 6'd0, 1'b0, 32'd0, 32'd0);
    send_request(sit_pkg::REQ_SET, 6'd3, 6'd0, 1'b1, 32'd0, 32'd0);
    send_request(sit_pkg::REQ_ADD, 6'd3, 6'd0, 1'b0, 32'd5, 32'd9);
    send_request(sit_pkg::REQ_READ, 6'd3, 6'd0, 1'b0, 32'd0, 32'd0);
    send_request(sit_pkg::REQ_SET, 6'd3, 6'd0, 1'b0, 32'd0, 32'd0);
    send_request(sit_pkg::REQ_READ, 6'd3, 6'd0, 1'b0, 32'd0, 32'd0);
    for (int k = 1; k <= 8; k++) begin
      send_request(sit_pkg::REQ_ADD, 6'd4, 6'd0, 1'b0, 32'(k * 1000),
                   32'(k * 1000 + 5));
    end
    send_request(sit_pkg::REQ_READ, 6'd4, 6'd0, 1'b0, 32'd0, 32'd0);
    send_request(sit_pkg::REQ_NONE, 6'd5, 6'd0, 1'b1, 32'd1, 32'd2);

    for (int p = 0; p < 4; p++) begin
      write_tolerance(tol_values[p]);
      idle_pct = idle_values[p];
      for (int n = 0; n < 21; n++) begin
        random_request();
      end
    end
    start = 1'b0;
    while (table_sb.pending_beats.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (table_sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
